[hw/rtl/sshh_pkg.sv]
// ----------------------------------------------------------------------------
// sshh_pkg
// Shared types and constants of the Space-Saving heavy hitter counter: port
// widths, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sshh_pkg;

	// fixed field widths of the ports
	localparam int TOPIC_W   = 32;
	localparam int CAP_W     = 7;
	localparam int OUT_IDX_W = 6;
	localparam int OUT_CNT_W = 16;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// controller states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // latch a new topic, clear scan results
		logic scan;    // walk the slot memory
		logic update;  // write back the slot and load the result beat
		logic cfg_we;  // capacity write
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;  // all used slots read and evaluated
	} status_t;

endpackage

[hw/rtl/space_saving_heavy_hitters.sv]
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters
// Space-Saving top-k frequent item counter with a controller and a
// slot-memory datapath.
// ----------------------------------------------------------------------------
// One topic is counted at a time. An item is accepted, its scan reads the
// used slots, and a write-back step then loads its result beat. The slot
// memory has a single registered read port, and every used slot is read
// once per item to find a match and the minimum. The scan ends once the
// read latency has passed and the last read has been evaluated, and the
// next topic is taken in the cycle after the write-back. The result sits
// in an output register, so the next topic is taken while a result still
// waits; a result that is still held back delays the write-back of the
// following item. The slot memory needs no clearing after reset: slots
// are filled in order and only the first used_slots entries are ever
// read. Topic 0 is answered with accepted low and leaves the table as it
// is. Capacity is written through the cfg channel while no item is in
// flight; lowering it drops the topics in the slots beyond it.
module space_saving_heavy_hitters import sshh_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TOPIC_W-1:0]   topic_id,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [OUT_IDX_W-1:0] slot_index,
	output logic [OUT_CNT_W-1:0] slot_count,
	output logic [OUT_CNT_W-1:0] slot_error,
	output logic                 evicted,
	output logic [TOPIC_W-1:0]   evicted_topic,
	output logic                 min_valid,
	output logic [OUT_IDX_W-1:0] min_slot,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CAP_W-1:0]     capacity
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	sshh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// slot memory and update logic
	sshh_dpath #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.topic_id      (topic_id),
		.capacity      (capacity),
		.accepted      (accepted),
		.slot_index    (slot_index),
		.slot_count    (slot_count),
		.slot_error    (slot_error),
		.evicted       (evicted),
		.evicted_topic (evicted_topic),
		.min_valid     (min_valid),
		.min_slot      (min_slot)
	);

	// busy after a topic beat until its result is produced
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a beat");

	// write-back always presents a result beat
	a_update_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid)
		else $error("write-back without result beat");

	// a rejected topic touches no slot
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> slot_index == '0 && slot_count == '0
			&& slot_error == '0 && !evicted && evicted_topic == '0)
		else $error("rejected topic reports a slot");

	// an eviction always replaces a real topic and leaves a nonempty table
	a_evict_real: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> accepted && evicted_topic != '0 && min_valid)
		else $error("eviction of an empty slot");

endmodule

[hw/rtl/sshh_ctrl.sv]
// ----------------------------------------------------------------------------
// sshh_ctrl
// Sequencer of the counter: accepts a topic, runs the slot scan, then
// issues the write-back once the output register is free. Owns the
// output valid flag.
// ----------------------------------------------------------------------------
module sshh_ctrl import sshh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    out_ready,
	output logic    out_valid,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_busy;

	assign out_busy  = out_valid_q && !out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		cmd.cfg_we = cfg_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nx  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_busy) begin
					cmd.update = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/sshh_dpath.sv]
// ----------------------------------------------------------------------------
// sshh_dpath
// Slot memory, scan unit and update logic. One scan over the used slots
// finds the first topic match, the lowest-index minimum and the runner-up
// minimum; the update then picks match, fill or eviction and derives the
// new minimum from those two candidates.
// ----------------------------------------------------------------------------
module sshh_dpath import sshh_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [TOPIC_W-1:0]   topic_id,
	input  logic [CAP_W-1:0]     capacity,
	output logic                 accepted,
	output logic [OUT_IDX_W-1:0] slot_index,
	output logic [OUT_CNT_W-1:0] slot_count,
	output logic [OUT_CNT_W-1:0] slot_error,
	output logic                 evicted,
	output logic [TOPIC_W-1:0]   evicted_topic,
	output logic                 min_valid,
	output logic [OUT_IDX_W-1:0] min_slot
);

	localparam int IW = $clog2(SLOTS);
	localparam int UW = $clog2(SLOTS + 1);
	localparam int CW = (UW > CAP_W) ? UW : CAP_W;
	localparam int CB = COUNT_BITS;
	localparam int WW = TOPIC_W + 2 * CB;
	localparam int XW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;
	localparam int KW = (CB > OUT_CNT_W) ? CB : OUT_CNT_W;
	localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

	// effective capacity: 0 acts as 1, saturate at the slot count
	function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CW-1:0] cx;
		cx = CW'(c);
		if (c == '0) begin
			return CW'(1);
		end else if (cx > CW'(SLOTS)) begin
			return CW'(SLOTS);
		end else begin
			return cx;
		end
	endfunction

	// configuration and fill count
	logic [CAP_W-1:0] capacity_q;
	logic [UW-1:0]    used_q;
	logic [CW-1:0]    eff_new;
	logic [CW-1:0]    eff_now;
	logic             table_full;
	logic             fill_new;

	assign eff_new    = eff_cap(capacity);
	assign eff_now    = eff_cap(capacity_q);
	assign table_full = !(CW'(used_q) < eff_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			used_q     <= '0;
		end else if (cmd.cfg_we) begin
			capacity_q <= capacity;
			if (CW'(used_q) > eff_new) begin
				used_q <= UW'(eff_new);
			end
		end else if (cmd.update && fill_new) begin
			used_q <= used_q + UW'(1);
		end
	end

	// topic of the item under work
	logic [TOPIC_W-1:0] topic_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			topic_q <= topic_id;
		end
	end

	// slot memory: {topic, count, error}, filled in slot order
	logic [WW-1:0] slot_mem_q [SLOTS];
	logic [WW-1:0] rdata_s1;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [UW-1:0] addr_q;
	logic          rd_en;

	assign rd_en = cmd.scan && (addr_q < used_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= slot_mem_q[addr_q[IW-1:0]];
		end
	end

	// scan address and read pipeline
	logic          rd_valid_s1;
	logic [IW-1:0] rd_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (cmd.start) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= addr_q[IW-1:0];
		end
	end

	assign status.scan_done = !rd_valid_s1 && !(addr_q < used_q);

	// scan evaluation: first match, minimum and runner-up minimum
	logic [TOPIC_W-1:0] rd_topic;
	logic [CB-1:0]      rd_cnt;
	logic [CB-1:0]      rd_err;

	assign rd_topic = rdata_s1[WW-1 -: TOPIC_W];
	assign rd_cnt   = rdata_s1[2*CB-1 -: CB];
	assign rd_err   = rdata_s1[CB-1:0];

	logic               found_q;
	logic [IW-1:0]      m_idx_q;
	logic [CB-1:0]      m_cnt_q;
	logic [CB-1:0]      m_err_q;
	logic               best_valid_q;
	logic [IW-1:0]      best_idx_q;
	logic [CB-1:0]      best_cnt_q;
	logic [TOPIC_W-1:0] best_topic_q;
	logic               sec_valid_q;
	logic [IW-1:0]      sec_idx_q;
	logic [CB-1:0]      sec_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			best_valid_q <= 1'b0;
			sec_valid_q  <= 1'b0;
		end else if (cmd.start) begin
			found_q      <= 1'b0;
			best_valid_q <= 1'b0;
			sec_valid_q  <= 1'b0;
		end else if (rd_valid_s1) begin
			if (!found_q && rd_topic == topic_q) begin
				found_q <= 1'b1;
			end
			if (!best_valid_q || rd_cnt < best_cnt_q) begin
				best_valid_q <= 1'b1;
				sec_valid_q  <= best_valid_q;
			end else if (!sec_valid_q || rd_cnt < sec_cnt_q) begin
				sec_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (!found_q && rd_topic == topic_q) begin
				m_idx_q <= rd_idx_s1;
				m_cnt_q <= rd_cnt;
				m_err_q <= rd_err;
			end
			if (!best_valid_q || rd_cnt < best_cnt_q) begin
				best_idx_q   <= rd_idx_s1;
				best_cnt_q   <= rd_cnt;
				best_topic_q <= rd_topic;
				sec_idx_q    <= best_idx_q;
				sec_cnt_q    <= best_cnt_q;
			end else if (!sec_valid_q || rd_cnt < sec_cnt_q) begin
				sec_idx_q <= rd_idx_s1;
				sec_cnt_q <= rd_cnt;
			end
		end
	end

	// update decision
	logic          acc;
	logic [IW-1:0] upd_idx;
	logic [CB-1:0] upd_cnt;
	logic [CB-1:0] upd_err;
	logic          upd_ev;
	logic          upd_minv;
	logic [IW-1:0] upd_mins;
	logic [CB-1:0] evict_base;
	logic          beat_sec;

	assign acc        = (topic_q != '0);
	assign evict_base = (best_cnt_q == CNT_MAX) ? CNT_MAX - CB'(1) : best_cnt_q;

	always_comb begin
		upd_idx  = '0;
		upd_cnt  = '0;
		upd_err  = '0;
		upd_ev   = 1'b0;
		fill_new = 1'b0;
		upd_minv = best_valid_q;
		upd_mins = best_valid_q ? best_idx_q : '0;
		beat_sec = 1'b0;
		if (acc) begin
			upd_minv = 1'b1;
			priority if (found_q) begin
				upd_idx = m_idx_q;
				upd_cnt = (m_cnt_q == CNT_MAX) ? m_cnt_q : m_cnt_q + CB'(1);
				upd_err = m_err_q;
			end else if (!table_full) begin
				upd_idx  = used_q[IW-1:0];
				upd_cnt  = CB'(1);
				fill_new = 1'b1;
			end else begin
				upd_idx = best_idx_q;
				upd_cnt = evict_base + CB'(1);
				upd_err = evict_base;
				upd_ev  = 1'b1;
			end
			// new minimum: only the touched slot can displace the old one
			beat_sec = !sec_valid_q || upd_cnt < sec_cnt_q
				|| (upd_cnt == sec_cnt_q && upd_idx < sec_idx_q);
			priority if (!best_valid_q) begin
				upd_mins = upd_idx;
			end else if (fill_new) begin
				upd_mins = (upd_cnt < best_cnt_q) ? upd_idx : best_idx_q;
			end else if (upd_idx == best_idx_q) begin
				upd_mins = beat_sec ? upd_idx : sec_idx_q;
			end else begin
				upd_mins = best_idx_q;
			end
		end
	end

	assign mem_we    = cmd.update && acc;
	assign mem_waddr = upd_idx;
	assign mem_wdata = {topic_q, upd_cnt, upd_err};

	// result beat register
	logic               acc_q;
	logic [IW-1:0]      idx_q;
	logic [CB-1:0]      cnt_q;
	logic [CB-1:0]      err_q;
	logic               ev_q;
	logic [TOPIC_W-1:0] evt_q;
	logic               minv_q;
	logic [IW-1:0]      mins_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			acc_q  <= acc;
			idx_q  <= upd_idx;
			cnt_q  <= upd_cnt;
			err_q  <= upd_err;
			ev_q   <= upd_ev;
			evt_q  <= upd_ev ? best_topic_q : '0;
			minv_q <= upd_minv;
			mins_q <= upd_mins;
		end
	end

	// fit internal widths to the port widths
	logic [XW-1:0] idx_ext;
	logic [XW-1:0] mins_ext;
	logic [KW-1:0] cnt_ext;
	logic [KW-1:0] err_ext;

	assign idx_ext  = XW'(idx_q);
	assign mins_ext = XW'(mins_q);
	assign cnt_ext  = KW'(cnt_q);
	assign err_ext  = KW'(err_q);

	assign accepted      = acc_q;
	assign slot_index    = idx_ext[OUT_IDX_W-1:0];
	assign slot_count    = cnt_ext[OUT_CNT_W-1:0];
	assign slot_error    = err_ext[OUT_CNT_W-1:0];
	assign evicted       = ev_q;
	assign evicted_topic = evt_q;
	assign min_valid     = minv_q;
	assign min_slot      = mins_ext[OUT_IDX_W-1:0];

endmodule
